// ===== hw/rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the strongly connected components engine.
// ----------------------------------------------------------------------------
package scc_pkg;

  // Fixed field widths of the item, result and configuration channels.
  localparam int KIND_W    = 2;
  localparam int EIDX_W    = 8;
  localparam int NODE_W    = 6;
  localparam int COMP_W    = 6;
  localparam int NCOUNT_W  = 7;
  localparam int ECOUNT_W  = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_EDGE = 2'd0,
    KIND_EDGE_SKIP = 2'd1,
    KIND_NODE_SKIP = 2'd2,
    KIND_RUN       = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT = 1'b0,
    CFG_EDGE_COUNT = 1'b1
  } cfg_idx_t;

endpackage

// ===== hw/rtl/scc_ram.sv =====
// ----------------------------------------------------------------------------
// scc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/strongly_connected_components.sv =====
// ----------------------------------------------------------------------------
// strongly_connected_components
// Kosaraju SCC engine over a RAM-resident edge list.
// ----------------------------------------------------------------------------
// Load, edge-skip and node-skip items are taken one per cycle. A run item
// clears the visited marks, makes a forward depth-first pass recording
// finishing order, clears the marks again, then a reverse pass over
// incoming edges that numbers components in discovery order, and finally
// emits one result per node in use with last flagged on the final node,
// min(node_count, NODES)-1. Every edge examined in a walk takes an edge RAM
// read (S_W_ED, S_W_NB), then, if it qualifies, a skip/visited RAM read of
// its far end (S_W_FC); each pop goes through S_W_ED and S_W_POP. A walk
// rescans the edge list from its saved position per stack level, so each
// pass examines up to nodes*edge_count edges. The depth-first stack lives
// in a RAM with the top entry held in registers. After reset the block
// clears the edge and node skip RAMs and takes no item meanwhile;
// configuration writes are always taken.
// ----------------------------------------------------------------------------
module strongly_connected_components
  import scc_pkg::*;
#(
  parameter int NODES = 64,
  parameter int EDGES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [EIDX_W-1:0]    in_edge_index,
  input  logic [NODE_W-1:0]    in_from_node,
  input  logic [NODE_W-1:0]    in_to_node,
  input  logic                 in_skip_flag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [NODE_W-1:0]    out_node_index,
  output logic [COMP_W-1:0]    out_component,
  output logic                 out_no_component,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int NW   = $clog2(NODES);
  localparam int NCW  = NW + 1;
  localparam int EW   = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int ECW  = EW + 1;
  localparam int SMAX = (NODES > EDGES) ? NODES : EDGES;
  localparam int SW   = $clog2(SMAX) + 1;
  localparam int STW  = NW + ECW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_VCLR,
    S_F_SEL, S_F_CHK,
    S_R_SEL, S_R_RD, S_R_CHK,
    S_W_ED, S_W_POP, S_W_NB, S_W_FC,
    S_E_RD, S_E_LD, S_E_OUT
  } state_t;

  state_t               state_r;
  logic [NCOUNT_W-1:0]  node_count_r;
  logic [ECOUNT_W-1:0]  edge_count_r;
  logic [SW-1:0]        swp_r;
  logic                 pass_rev_r;
  logic [NCW-1:0]       i_r;
  logic [NCW-1:0]       fin_r;
  logic [NCW-1:0]       depth_r;
  logic [NW-1:0]        v_r;
  logic [ECW-1:0]       e_r;
  logic [NW-1:0]        cand_r;
  logic [NW-1:0]        far_r;
  logic [NW-1:0]        comp_r;

  // Clamped run limits.
  logic [NCW-1:0] n_w;
  logic [ECW-1:0] ec_w;
  assign n_w  = (32'(node_count_r) > NODES) ? NCW'(NODES) : NCW'(node_count_r);
  assign ec_w = (32'(edge_count_r) > EDGES) ? ECW'(EDGES) : ECW'(edge_count_r);

  // RAM ports
  logic                 edge_we, esk_we, nsk_we, vis_we, comp_we, fin_we, stk_we;
  logic [EW-1:0]        edge_waddr, esk_waddr, edge_raddr;
  logic [2*NODE_W-1:0]  edge_wdata, edge_rdata;
  logic                 esk_wdata, esk_rdata;
  logic [NW-1:0]        nsk_waddr, nsk_raddr, vis_waddr, vis_raddr;
  logic                 nsk_wdata, nsk_rdata, vis_wdata, vis_rdata;
  logic [NW-1:0]        comp_waddr, comp_raddr, comp_wdata, comp_rdata;
  logic [NW-1:0]        fin_waddr, fin_raddr, fin_wdata, fin_rdata;
  logic [NW-1:0]        stk_waddr, stk_raddr;
  logic [STW-1:0]       stk_wdata, stk_rdata;

  logic                 in_xfer;
  logic                 ed_done;
  logic [NODE_W-1:0]    near_w, far_w;
  logic                 edge_ok;
  logic                 far_ok;
  logic                 walk_done;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign ed_done   = (e_r >= ec_w);
  assign walk_done = ed_done && (depth_r == NCW'(1));
  assign near_w    = pass_rev_r ? edge_rdata[NODE_W-1:0] : edge_rdata[2*NODE_W-1:NODE_W];
  assign far_w     = pass_rev_r ? edge_rdata[2*NODE_W-1:NODE_W] : edge_rdata[NODE_W-1:0];
  assign edge_ok   = (32'(near_w) == 32'(v_r)) && !esk_rdata && (32'(far_w) < 32'(n_w));
  assign far_ok    = !nsk_rdata && !vis_rdata;

  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = EW'(in_edge_index);
    edge_wdata = {in_from_node, in_to_node};
    edge_raddr = EW'(e_r);
    esk_we     = 1'b0;
    esk_waddr  = EW'(in_edge_index);
    esk_wdata  = in_skip_flag;
    nsk_we     = 1'b0;
    nsk_waddr  = NW'(in_from_node);
    nsk_wdata  = in_skip_flag;
    nsk_raddr  = NW'(i_r);
    vis_we     = 1'b0;
    vis_waddr  = far_r;
    vis_wdata  = 1'b1;
    vis_raddr  = NW'(i_r);
    comp_we    = 1'b0;
    comp_waddr = far_r;
    comp_wdata = comp_r;
    comp_raddr = NW'(i_r);
    fin_we     = 1'b0;
    fin_waddr  = NW'(fin_r);
    fin_wdata  = v_r;
    fin_raddr  = NW'(i_r - NCW'(1));
    stk_we     = 1'b0;
    stk_waddr  = NW'(depth_r - NCW'(1));
    stk_wdata  = {v_r, e_r + ECW'(1)};
    stk_raddr  = NW'(depth_r - NCW'(2));
    case (state_r)
      S_CLR: begin
        nsk_we    = (32'(swp_r) < NODES);
        nsk_waddr = NW'(swp_r);
        nsk_wdata = 1'b0;
        esk_we    = (32'(swp_r) < EDGES);
        esk_waddr = EW'(swp_r);
        esk_wdata = 1'b0;
      end
      S_IDLE: begin
        if (in_xfer) begin
          edge_we = (kind_t'(in_kind) == KIND_LOAD_EDGE) && (32'(in_edge_index) < EDGES);
          esk_we  = (kind_t'(in_kind) == KIND_EDGE_SKIP) && (32'(in_edge_index) < EDGES);
          nsk_we  = (kind_t'(in_kind) == KIND_NODE_SKIP) && (32'(in_from_node) < NODES);
        end
      end
      S_VCLR: begin
        vis_we    = 1'b1;
        vis_waddr = NW'(swp_r);
        vis_wdata = 1'b0;
      end
      S_F_CHK: begin
        vis_we    = (i_r != n_w) && !vis_rdata && !nsk_rdata;
        vis_waddr = NW'(i_r);
      end
      S_R_RD: begin
        vis_raddr = fin_rdata;
      end
      S_R_CHK: begin
        vis_we     = !vis_rdata;
        vis_waddr  = cand_r;
        comp_we    = !vis_rdata;
        comp_waddr = cand_r;
      end
      S_W_ED: begin
        fin_we = ed_done && !pass_rev_r;
      end
      S_W_NB: begin
        nsk_raddr = NW'(far_w);
        vis_raddr = NW'(far_w);
      end
      S_W_FC: begin
        vis_we  = far_ok;
        comp_we = far_ok && pass_rev_r;
        stk_we  = far_ok && (32'(depth_r) < NODES);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      node_count_r <= NCOUNT_W'(64);
      edge_count_r <= '0;
      swp_r        <= '0;
      pass_rev_r   <= 1'b0;
      i_r          <= '0;
      fin_r        <= '0;
      depth_r      <= '0;
      comp_r       <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NODE_COUNT: node_count_r <= cfg_data[NCOUNT_W-1:0];
          CFG_EDGE_COUNT: edge_count_r <= cfg_data[ECOUNT_W-1:0];
          default: begin
          end
        endcase
      end
      case (state_r)
        S_CLR: begin
          swp_r <= swp_r + SW'(1);
          if (32'(swp_r) == SMAX - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer && (kind_t'(in_kind) == KIND_RUN)) begin
            fin_r      <= '0;
            i_r        <= '0;
            comp_r     <= '0;
            pass_rev_r <= 1'b0;
            swp_r      <= '0;
            state_r    <= S_VCLR;
          end
        end
        S_VCLR: begin
          swp_r <= swp_r + SW'(1);
          if (32'(swp_r) == NODES - 1) begin
            state_r <= pass_rev_r ? S_R_SEL : S_F_SEL;
          end
        end
        S_F_SEL: begin
          if (i_r == n_w) begin
            pass_rev_r <= 1'b1;
            i_r        <= fin_r;
            swp_r      <= '0;
            state_r    <= S_VCLR;
          end else begin
            state_r <= S_F_CHK;
          end
        end
        S_F_CHK: begin
          if (!vis_rdata && !nsk_rdata) begin
            v_r     <= NW'(i_r);
            e_r     <= '0;
            depth_r <= NCW'(1);
            state_r <= S_W_ED;
          end else begin
            i_r     <= i_r + NCW'(1);
            state_r <= S_F_SEL;
          end
        end
        S_R_SEL: begin
          if (i_r == '0) begin
            state_r <= (n_w == '0) ? S_IDLE : S_E_RD;
          end else begin
            state_r <= S_R_RD;
          end
        end
        S_R_RD: begin
          cand_r  <= fin_rdata;
          state_r <= S_R_CHK;
        end
        S_R_CHK: begin
          if (!vis_rdata) begin
            v_r     <= cand_r;
            e_r     <= '0;
            depth_r <= NCW'(1);
            state_r <= S_W_ED;
          end else begin
            i_r     <= i_r - NCW'(1);
            state_r <= S_R_SEL;
          end
        end
        S_W_ED: begin
          if (ed_done) begin
            if (!pass_rev_r) begin
              fin_r <= fin_r + NCW'(1);
            end
            depth_r <= depth_r - NCW'(1);
            if (walk_done) begin
              if (pass_rev_r) begin
                comp_r  <= comp_r + NW'(1);
                i_r     <= i_r - NCW'(1);
                state_r <= S_R_SEL;
              end else begin
                i_r     <= i_r + NCW'(1);
                state_r <= S_F_SEL;
              end
            end else begin
              state_r <= S_W_POP;
            end
          end else begin
            state_r <= S_W_NB;
          end
        end
        S_W_POP: begin
          v_r     <= stk_rdata[STW-1:ECW];
          e_r     <= stk_rdata[ECW-1:0];
          state_r <= S_W_ED;
        end
        S_W_NB: begin
          far_r <= NW'(far_w);
          if (edge_ok) begin
            state_r <= S_W_FC;
          end else begin
            e_r     <= e_r + ECW'(1);
            state_r <= S_W_ED;
          end
        end
        S_W_FC: begin
          if (far_ok && (32'(depth_r) < NODES)) begin
            v_r     <= far_r;
            e_r     <= '0;
            depth_r <= depth_r + NCW'(1);
          end else begin
            e_r <= e_r + ECW'(1);
          end
          state_r <= S_W_ED;
        end
        S_E_RD: begin
          state_r <= S_E_LD;
        end
        S_E_LD: begin
          out_node_index   <= NODE_W'(i_r);
          out_component    <= nsk_rdata ? '0 : COMP_W'(comp_rdata);
          out_no_component <= nsk_rdata;
          out_last         <= (i_r + NCW'(1) == n_w);
          out_valid        <= 1'b1;
          state_r          <= S_E_OUT;
        end
        S_E_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            i_r       <= i_r + NCW'(1);
            state_r   <= out_last ? S_IDLE : S_E_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  scc_ram #(.WIDTH(2*NODE_W), .DEPTH(EDGES)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  scc_ram #(.WIDTH(1), .DEPTH(EDGES)) u_eskip_ram (
    .clk(clk), .we(esk_we), .waddr(esk_waddr), .wdata(esk_wdata),
    .raddr(edge_raddr), .rdata(esk_rdata)
  );

  scc_ram #(.WIDTH(1), .DEPTH(NODES)) u_nskip_ram (
    .clk(clk), .we(nsk_we), .waddr(nsk_waddr), .wdata(nsk_wdata),
    .raddr(nsk_raddr), .rdata(nsk_rdata)
  );

  scc_ram #(.WIDTH(1), .DEPTH(NODES)) u_visit_ram (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata)
  );

  scc_ram #(.WIDTH(NW), .DEPTH(NODES)) u_comp_ram (
    .clk(clk), .we(comp_we), .waddr(comp_waddr), .wdata(comp_wdata),
    .raddr(comp_raddr), .rdata(comp_rdata)
  );

  scc_ram #(.WIDTH(NW), .DEPTH(NODES)) u_finish_ram (
    .clk(clk), .we(fin_we), .waddr(fin_waddr), .wdata(fin_wdata),
    .raddr(fin_raddr), .rdata(fin_rdata)
  );

  scc_ram #(.WIDTH(STW), .DEPTH(NODES)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

`ifndef SYNTHESIS
  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("item accepted while result pending");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= NODES) else $error("walk stack overflow");
  a_walk_has_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W_ED || state_r == S_W_NB || state_r == S_W_FC) |-> depth_r != '0)
    else $error("walk with empty stack");
  a_finish_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fin_r) <= NODES) else $error("finish order overflow");
`endif

endmodule
